>>> rtl/btr_pkg.sv
// Shared types, codes and helpers for the bitmap text renderer.
// Used by every module of the block but btr_ram; depends on nothing else.

package btr_pkg;

   // Command codes of the request word.
   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_CURSOR = 2'd1,
      CMD_DRAW   = 2'd2
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_SCALE_X       = 3'd0,
      CSR_SCALE_Y       = 3'd1,
      CSR_FG_COLOR      = 3'd2,
      CSR_BG_COLOR      = 3'd3,
      CSR_SCREEN_WIDTH  = 3'd4,
      CSR_SCREEN_HEIGHT = 3'd5
   } csr_index_type;

   // Kind of work queued for the drawing engine.
   typedef enum logic {
      JOB_LOAD = 1'b0,
      JOB_DRAW = 1'b1
   } job_kind_type;

   // Back engine sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_DOT    = 2'd1,
      BK_SPACER = 2'd2,
      BK_FINISH = 2'd3
   } back_state_type;

   localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
   localparam logic [7:0] CHAR_RETURN     = 8'd13;
   localparam logic [7:0] HIGH_CODE_START = 8'd176;
   localparam logic [2:0] LAST_COLUMN     = 3'd4;   // five glyph columns
   localparam logic [2:0] LAST_ROW        = 3'd7;   // eight glyph rows

   localparam int QUEUE_DEPTH = 4;

   // Configuration after range limiting.
   typedef struct packed {
      logic [3:0]  sx;
      logic [3:0]  sy;
      logic [15:0] fg;
      logic [15:0] bg;
      logic [10:0] scr_w;
      logic [10:0] scr_h;
   } cfg_type;

   // One queued job between front and back.
   typedef struct packed {
      job_kind_type       kind;
      logic [10:0]        addr;
      logic [7:0]         data;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [7:0]         code;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Width of one character cell: six times the horizontal scale.
   function automatic logic [5:0] cell_width(input logic [3:0] sx);
      cell_width = {sx, 2'b00} + {1'b0, sx, 1'b0};
   endfunction

   // Height of one text line: eight times the vertical scale.
   function automatic logic [6:0] line_height(input logic [3:0] sy);
      line_height = {sy, 3'b000};
   endfunction

endpackage

>>> rtl/btr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.

module btr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/btr_queue.sv
// Short job queue between the command front end and the drawing engine.
// Depends on btr_pkg for the job type and queue depth.

module btr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  btr_pkg::job_type          push_job,
   input  logic                      pop,
   output btr_pkg::job_type          head,
   output btr_pkg::queue_status_type status
);

   localparam int PW = $clog2(btr_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(btr_pkg::QUEUE_DEPTH + 1);

   btr_pkg::job_type entry_ff [btr_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(btr_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> rtl/btr_front.sv
// Command front end: decodes request words, keeps the text cursor and
// queues glyph loads and draw jobs. Depends on btr_pkg.

module btr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  btr_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [7:0]                req_char_code,
   input  logic [10:0]               req_glyph_addr,
   input  logic [7:0]                req_glyph_byte,
   input  logic signed [15:0]        req_new_cursor_x,
   input  logic signed [15:0]        req_new_cursor_y,
   output logic                      push,
   output btr_pkg::job_type          push_job,
   input  btr_pkg::queue_status_type q_status
);

   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;

   logic               accept;
   logic signed [17:0] col_wide;
   logic signed [17:0] cell_w;
   logic signed [17:0] scr_w;
   logic [15:0]        line_h;
   logic               wrap;
   logic [15:0]        draw_x;
   logic [15:0]        draw_y;
   logic [7:0]         glyph_code;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign col_wide   = {{2{col_ff[15]}}, col_ff};
   assign cell_w     = {12'd0, btr_pkg::cell_width(cfg.sx)};
   assign scr_w      = {7'd0, cfg.scr_w};
   assign line_h     = {9'd0, btr_pkg::line_height(cfg.sy)};
   assign wrap       = (col_wide + cell_w) > scr_w;
   assign draw_x     = wrap ? 16'd0 : col_ff;
   assign draw_y     = wrap ? row_ff + line_h : row_ff;
   // Codes from the high range skip one glyph, wrapping within a byte.
   assign glyph_code = (req_char_code >= btr_pkg::HIGH_CODE_START) ?
                       req_char_code + 8'd1 : req_char_code;

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      push          = 1'b0;
      push_job.kind = btr_pkg::JOB_LOAD;
      push_job.addr = req_glyph_addr;
      push_job.data = req_glyph_byte;
      push_job.x    = draw_x;
      push_job.y    = draw_y;
      push_job.code = glyph_code;
      if (accept) begin
         case (req_command)
            btr_pkg::CMD_LOAD: begin
               push = 1'b1;
            end
            btr_pkg::CMD_CURSOR: begin
               col_in = req_new_cursor_x;
               row_in = req_new_cursor_y;
            end
            btr_pkg::CMD_DRAW: begin
               if (req_char_code == btr_pkg::CHAR_NEWLINE) begin
                  col_in = 16'd0;
                  row_in = row_ff + line_h;
               end else if (req_char_code != btr_pkg::CHAR_RETURN) begin
                  push          = 1'b1;
                  push_job.kind = btr_pkg::JOB_DRAW;
                  col_in        = draw_x + cell_w[15:0];
                  row_in        = draw_y;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

>>> rtl/btr_back.sv
// Drawing engine (uses btr_pkg, btr_ram): owns the glyph store, walks a
// glyph one dot per cycle while not stalled and emits clipped rectangles.

module btr_back #(
   parameter int GLYPH_STORE_DEPTH = 2048,
   localparam int AW = $clog2(GLYPH_STORE_DEPTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  btr_pkg::cfg_type          cfg,
   input  btr_pkg::job_type          head,
   input  btr_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [15:0]        rsp_rect_x,
   output logic signed [15:0]        rsp_rect_y,
   output logic [6:0]                rsp_rect_w,
   output logic [6:0]                rsp_rect_h,
   output logic [15:0]               rsp_color,
   output logic                      rsp_last
);

   btr_pkg::back_state_type state_ff, state_in;

   logic [2:0]         col_ff, col_in;
   logic [2:0]         row_ff, row_in;
   logic signed [17:0] px_ff, px_in;
   logic signed [17:0] py_ff, py_in;
   logic signed [17:0] y_ff, y_in;
   logic [AW-1:0]      base_ff, base_in;

   // Held rectangle: it becomes a response once the next one appears or
   // the character ends, which is when its last flag is known.
   logic               hold_valid_ff, hold_valid_in;
   logic [15:0]        hold_x_ff, hold_y_ff, hold_color_ff;
   logic [6:0]         hold_w_ff, hold_h_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_x_ff, rsp_y_ff, rsp_color_ff;
   logic [6:0]         rsp_w_ff, rsp_h_ff;
   logic               rsp_last_ff;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [7:0]         ram_rd_data;

   logic signed [17:0] scr_w_s, scr_h_s;
   logic signed [17:0] head_x, head_y;
   logic signed [17:0] cell_w, line_h;
   logic signed [17:0] dot_w, dot_h, full_h;
   logic signed [17:0] px_end, py_end;
   logic signed [17:0] w_val, h_val;
   logic [AW-1:0]      head_base;
   logic               head_visible;
   logic               opaque, unit, dot_bit, in_bounds, no_clip;
   logic               step_en, gen, flush_last, out_load;
   logic [15:0]        gen_color;

   btr_ram #(
      .WIDTH (8),
      .DEPTH (GLYPH_STORE_DEPTH)
   ) u_glyph_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (head.data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign scr_w_s   = {7'd0, cfg.scr_w};
   assign scr_h_s   = {7'd0, cfg.scr_h};
   assign head_x    = {{2{head.x[15]}}, head.x};
   assign head_y    = {{2{head.y[15]}}, head.y};
   assign cell_w    = {12'd0, btr_pkg::cell_width(cfg.sx)};
   assign line_h    = {11'd0, btr_pkg::line_height(cfg.sy)};
   assign head_base = AW'({head.code, 2'b00}) + AW'(head.code);
   assign head_visible = !((head_x >= scr_w_s) || (head_y >= scr_h_s) ||
                           (head_x + cell_w - 18'sd1 < 18'sd0) ||
                           (head_y + line_h - 18'sd1 < 18'sd0));

   assign opaque  = (cfg.bg != cfg.fg);
   assign unit    = (cfg.sx == 4'd1) && (cfg.sy == 4'd1);
   assign dot_bit = ram_rd_data[row_ff];
   assign dot_w   = {14'd0, cfg.sx};
   assign dot_h   = {14'd0, cfg.sy};
   assign full_h  = (state_ff == btr_pkg::BK_SPACER) ? line_h : dot_h;
   assign px_end  = px_ff + dot_w - 18'sd1;
   assign py_end  = py_ff + full_h - 18'sd1;
   // At unit scale the spacer column is sent as it is, without clipping.
   assign no_clip = unit && (state_ff == btr_pkg::BK_SPACER);
   assign w_val   = (!no_clip && px_end >= scr_w_s) ? scr_w_s - px_ff : dot_w;
   assign h_val   = (!no_clip && py_end >= scr_h_s) ? scr_h_s - py_ff : full_h;

   always_comb begin
      if (no_clip) begin
         in_bounds = 1'b1;
      end else if (unit) begin
         in_bounds = (px_ff >= 18'sd0) && (px_ff < scr_w_s) &&
                     (py_ff >= 18'sd0) && (py_ff < scr_h_s);
      end else begin
         in_bounds = (px_ff < scr_w_s) && (py_ff < scr_h_s);
      end
   end

   assign step_en = !hold_valid_ff || !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         btr_pkg::BK_IDLE: begin
            if (!q_status.empty && head.kind == btr_pkg::JOB_DRAW && head_visible) begin
               state_in = btr_pkg::BK_DOT;
            end
         end
         btr_pkg::BK_DOT: begin
            if (step_en && row_ff == btr_pkg::LAST_ROW &&
                col_ff == btr_pkg::LAST_COLUMN) begin
               state_in = btr_pkg::BK_SPACER;
            end
         end
         btr_pkg::BK_SPACER: begin
            if (step_en) begin
               state_in = btr_pkg::BK_FINISH;
            end
         end
         btr_pkg::BK_FINISH: begin
            if (step_en) begin
               state_in = btr_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = btr_pkg::BK_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      pop         = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(head.addr);
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_base;
      gen         = 1'b0;
      gen_color   = cfg.bg;
      flush_last  = 1'b0;
      case (state_ff)
         btr_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (head.kind == btr_pkg::JOB_LOAD) begin
                  ram_wr_en = (32'(head.addr) < GLYPH_STORE_DEPTH);
               end else begin
                  ram_rd_en = head_visible;
               end
            end
         end
         btr_pkg::BK_DOT: begin
            gen_color = dot_bit ? cfg.fg : cfg.bg;
            gen       = step_en && (dot_bit || opaque) && in_bounds;
            if (step_en && row_ff == btr_pkg::LAST_ROW &&
                col_ff != btr_pkg::LAST_COLUMN) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = base_ff + AW'(col_ff + 3'd1);
            end
         end
         btr_pkg::BK_SPACER: begin
            gen = step_en && opaque && in_bounds;
         end
         btr_pkg::BK_FINISH: begin
            flush_last = step_en && hold_valid_ff;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      y_in    = y_ff;
      base_in = base_ff;
      if (state_ff == btr_pkg::BK_IDLE) begin
         col_in  = '0;
         row_in  = '0;
         px_in   = head_x;
         py_in   = head_y;
         y_in    = head_y;
         base_in = head_base;
      end else if (state_ff == btr_pkg::BK_DOT && step_en) begin
         if (row_ff == btr_pkg::LAST_ROW) begin
            row_in = '0;
            col_in = col_ff + 3'd1;
            px_in  = px_ff + dot_w;
            py_in  = y_ff;
         end else begin
            row_in = row_ff + 3'd1;
            py_in  = py_ff + dot_h;
         end
      end
      out_load      = (gen && hold_valid_ff) || flush_last;
      hold_valid_in = gen ? 1'b1 : (flush_last ? 1'b0 : hold_valid_ff);
      rsp_valid_in  = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= btr_pkg::BK_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      row_ff  <= row_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      y_ff    <= y_in;
      base_ff <= base_in;
      if (gen) begin
         hold_x_ff     <= px_ff[15:0];
         hold_y_ff     <= py_ff[15:0];
         hold_w_ff     <= w_val[6:0];
         hold_h_ff     <= h_val[6:0];
         hold_color_ff <= gen_color;
      end
      if (out_load) begin
         rsp_x_ff     <= hold_x_ff;
         rsp_y_ff     <= hold_y_ff;
         rsp_w_ff     <= hold_w_ff;
         rsp_h_ff     <= hold_h_ff;
         rsp_color_ff <= hold_color_ff;
         rsp_last_ff  <= flush_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rect_x = rsp_x_ff;
   assign rsp_rect_y = rsp_y_ff;
   assign rsp_rect_w = rsp_w_ff;
   assign rsp_rect_h = rsp_h_ff;
   assign rsp_color  = rsp_color_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> rtl/bitmap_text_to_rectangles.sv
// Top level of the bitmap text renderer: configuration registers, command
// front end, job queue and drawing engine. Depends on btr_pkg, btr_front,
// btr_queue and btr_back.
//
//   channel   ports        handshake           word
//   request   req_*        req_valid/ready     one command
//   response  rsp_*        rsp_valid/ready     one filled rectangle
//   config    csr_*        csr_write_en        one register write
//
// The front end takes one request word per cycle while the job queue has
// room; cursor moves, newlines and carriage returns finish there.
// The drawing engine handles a glyph load or an invisible character in
// its idle state alone. A visible one takes one dot per cycle over the
// 40 glyph dots while the output does not stall, then the spacer column
// and the closing step. The glyph store's registered read port for the
// next column is read in the last row of the current one.
// Reset is synchronous and clears the cursor, the queue, the engine and
// the registers to their defaults; the glyph store holds no reset value.

module bitmap_text_to_rectangles #(
   parameter int GLYPH_STORE_DEPTH = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_char_code,
   input  logic [10:0]        req_glyph_addr,
   input  logic [7:0]         req_glyph_byte,
   input  logic signed [15:0] req_new_cursor_x,
   input  logic signed [15:0] req_new_cursor_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_rect_x,
   output logic signed [15:0] rsp_rect_y,
   output logic [6:0]         rsp_rect_w,
   output logic [6:0]         rsp_rect_h,
   output logic [15:0]        rsp_color,
   output logic               rsp_last,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   // Raw register contents, exactly as written.
   logic [3:0]  scale_x_ff, scale_y_ff;
   logic [15:0] fg_color_ff, bg_color_ff;
   logic [10:0] screen_width_ff, screen_height_ff;

   btr_pkg::cfg_type          cfg;
   btr_pkg::job_type          q_push_job;
   btr_pkg::job_type          q_head;
   btr_pkg::queue_status_type q_status;
   logic                      q_push;
   logic                      q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff       <= 4'd1;
         scale_y_ff       <= 4'd1;
         fg_color_ff      <= 16'hFFFF;
         bg_color_ff      <= 16'hFFFF;
         screen_width_ff  <= 11'd128;
         screen_height_ff <= 11'd160;
      end else if (csr_write_en) begin
         case (csr_index)
            btr_pkg::CSR_SCALE_X:       scale_x_ff       <= csr_write_data[3:0];
            btr_pkg::CSR_SCALE_Y:       scale_y_ff       <= csr_write_data[3:0];
            btr_pkg::CSR_FG_COLOR:      fg_color_ff      <= csr_write_data;
            btr_pkg::CSR_BG_COLOR:      bg_color_ff      <= csr_write_data;
            btr_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data[10:0];
            btr_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_write_data[10:0];
            default: begin
            end
         endcase
      end
   end

   // Scales are limited to 1..8 and screen sizes to 1..1024, so a zero
   // acts as the smallest legal value and anything larger as the limit.
   always_comb begin
      cfg.fg    = fg_color_ff;
      cfg.bg    = bg_color_ff;
      cfg.sx    = (scale_x_ff == 4'd0) ? 4'd1 :
                  (scale_x_ff > 4'd8) ? 4'd8 : scale_x_ff;
      cfg.sy    = (scale_y_ff == 4'd0) ? 4'd1 :
                  (scale_y_ff > 4'd8) ? 4'd8 : scale_y_ff;
      cfg.scr_w = (screen_width_ff == 11'd0) ? 11'd1 :
                  (screen_width_ff > 11'd1024) ? 11'd1024 : screen_width_ff;
      cfg.scr_h = (screen_height_ff == 11'd0) ? 11'd1 :
                  (screen_height_ff > 11'd1024) ? 11'd1024 : screen_height_ff;
   end

   // The front end resolves every cursor move, so each queued draw job
   // already carries its final screen position.
   btr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_char_code    (req_char_code),
      .req_glyph_addr   (req_glyph_addr),
      .req_glyph_byte   (req_glyph_byte),
      .req_new_cursor_x (req_new_cursor_x),
      .req_new_cursor_y (req_new_cursor_y),
      .push             (q_push),
      .push_job         (q_push_job),
      .q_status         (q_status)
   );

   // Glyph loads travel through the queue as well, so they reach the
   // store in order with the draws that read it.
   btr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   btr_back #(
      .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (q_head),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_rect_x (rsp_rect_x),
      .rsp_rect_y (rsp_rect_y),
      .rsp_rect_w (rsp_rect_w),
      .rsp_rect_h (rsp_rect_h),
      .rsp_color  (rsp_color),
      .rsp_last   (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("job popped from an empty queue");

   a_rect_size_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rect_w != 7'd0 && rsp_rect_w <= 7'd64 &&
                     rsp_rect_h != 7'd0 && rsp_rect_h <= 7'd64))
      else $error("rectangle size outside 1..64");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the bitmap text renderer: sends command words,
// predicts the filled rectangles of every character and checks each result.
// Depends on btr_pkg and the bitmap_text_to_rectangles RTL; nothing else.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GLYPH_DEPTH   = 2048;
   localparam int GLYPH_COLS    = 5;
   localparam int GLYPH_ROWS    = 8;
   localparam int CELL_DOTS     = 6;           // five glyph columns plus the spacer
   localparam int FONT_BYTES    = 256 * GLYPH_COLS;
   localparam int LOADED_COUNT  = 8;           // glyphs that draws are allowed to reach
   localparam int MAX_SCALE     = 8;
   localparam int MAX_SCREEN    = 1024;
   localparam int SETTLE_CYCLES = 300;         // covers a full job queue of visible glyphs
   localparam int REPORT_LIMIT  = 10;
   localparam longint TIMEOUT_NS = 18_000_000; // upper bound on the whole run

   // The command field has one spare code that the block must ignore.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // One rectangle as it leaves the block on the result channel.
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [6:0]         w;
      logic [6:0]         h;
      logic [15:0]        color;
      logic               last;
   } rect_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_command = btr_pkg::CMD_LOAD;
   logic [7:0]             req_char_code = '0;
   logic [10:0]            req_glyph_addr = '0;
   logic [7:0]             req_glyph_byte = '0;
   logic signed [15:0]     req_new_cursor_x = '0;
   logic signed [15:0]     req_new_cursor_y = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [15:0]     rsp_rect_x;
   logic signed [15:0]     rsp_rect_y;
   logic [6:0]             rsp_rect_w;
   logic [6:0]             rsp_rect_h;
   logic [15:0]            rsp_color;
   logic                   rsp_last;
   logic                   csr_write_en = 1'b0;
   btr_pkg::csr_index_type csr_index = btr_pkg::CSR_SCALE_X;
   logic [15:0]            csr_write_data = '0;

   bitmap_text_to_rectangles #(.GLYPH_STORE_DEPTH(GLYPH_DEPTH)) u_dut (.*);

   always #6 clock = ~clock;

   // Our own copy of the block's registers, cursor and glyph store. The
   // registers hold the raw written values; range limiting happens per draw.
   logic [3:0]  reg_sx = 4'd1;
   logic [3:0]  reg_sy = 4'd1;
   logic [15:0] reg_fg = 16'hFFFF;
   logic [15:0] reg_bg = 16'hFFFF;
   logic [10:0] reg_w  = 11'd128;
   logic [10:0] reg_h  = 11'd160;
   logic [15:0] cur_col = '0;
   logic [15:0] cur_row = '0;
   logic [7:0]  glyph_mem [GLYPH_DEPTH];

   rect_type pending_rects[$];   // rectangles predicted but not yet seen
   int       errors    = 0;
   int       gap_pct   = 0;      // chance that the sender idles before a word
   int       stall_pct = 0;      // chance that the receiver holds off a cycle

   function automatic int clamp_int(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // The glyphs that are loaded before any text is drawn.
   function automatic int loaded_glyph(int k);
      case (k)
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 65;
         4: return 175;
         5: return 177;
         6: return 178;
         default: return 255;
      endcase
   endfunction

   // Character codes whose glyph is among the loaded ones, high codes included.
   function automatic logic [7:0] pick_code();
      case ($urandom_range(8))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd2;
         3: return 8'd65;
         4: return 8'd175;
         5: return 8'd176;   // uses glyph 177
         6: return 8'd177;   // uses glyph 178
         7: return 8'd254;   // uses glyph 255
         default: return 8'd255;   // wraps around to glyph 0
      endcase
   endfunction

   function automatic void push_rect(int x, int y, int w, int h, logic [15:0] shade);
      rect_type r;
      r.x     = x[15:0];
      r.y     = y[15:0];
      r.w     = w[6:0];
      r.h     = h[6:0];
      r.color = shade;
      r.last  = 1'b0;
      pending_rects.push_back(r);
   endfunction

   // A scaled rectangle is dropped past the right or bottom edge and cut back
   // there, but it is never trimmed on the left or top.
   function automatic void clip_rect(int x, int y, int w, int h, logic [15:0] shade,
                                     int scr_w, int scr_h);
      if (x >= scr_w || y >= scr_h) return;
      if (x + w - 1 >= scr_w) w = scr_w - x;
      if (y + h - 1 >= scr_h) h = scr_h - y;
      push_rect(x, y, w, h, shade);
   endfunction

   // Expands one glyph at (x, y): dots column by column, top to bottom, then
   // the spacer column, and flags the final rectangle of the character.
   function automatic void draw_glyph(int x, int y, logic [7:0] code, int sx, int sy,
                                      int scr_w, int scr_h);
      logic [7:0]  bits;
      logic [15:0] shade;
      int          glyph;
      int          idx;
      int          first;
      bit          opaque;
      bit          unit;
      opaque = (reg_bg != reg_fg);
      unit   = (sx == 1 && sy == 1);
      if (x >= scr_w || y >= scr_h || x + CELL_DOTS * sx - 1 < 0 ||
          y + GLYPH_ROWS * sy - 1 < 0) return;
      // High codes skip one glyph, wrapping within eight bits.
      glyph = (code >= btr_pkg::HIGH_CODE_START) ? int'(8'(code + 8'd1)) : int'(code);
      first = pending_rects.size();
      for (int i = 0; i < GLYPH_COLS; i++) begin
         idx  = glyph * GLYPH_COLS + i;
         bits = (idx < GLYPH_DEPTH) ? glyph_mem[idx] : 8'h00;
         for (int j = 0; j < GLYPH_ROWS; j++) begin
            if (bits[j]) shade = reg_fg;
            else if (opaque) shade = reg_bg;
            else continue;
            if (unit) begin
               if (x + i >= 0 && x + i < scr_w && y + j >= 0 && y + j < scr_h)
                  push_rect(x + i, y + j, 1, 1, shade);
            end else begin
               clip_rect(x + i * sx, y + j * sy, sx, sy, shade, scr_w, scr_h);
            end
         end
      end
      if (opaque) begin
         // At unit scale the spacer goes out unclipped.
         if (unit) push_rect(x + GLYPH_COLS, y, 1, GLYPH_ROWS, reg_bg);
         else clip_rect(x + GLYPH_COLS * sx, y, sx, GLYPH_ROWS * sy, reg_bg, scr_w, scr_h);
      end
      if (pending_rects.size() > first) pending_rects[$].last = 1'b1;
   endfunction

   // Applies one accepted request word to our state and queues the
   // rectangles that it must produce.
   function automatic void predict_rectangles(logic [1:0] cmd, logic [7:0] code,
                                              logic [10:0] addr, logic [7:0] data,
                                              logic [15:0] nx, logic [15:0] ny);
      int sx;
      int sy;
      int scr_w;
      int scr_h;
      sx    = clamp_int(int'(reg_sx), 1, MAX_SCALE);
      sy    = clamp_int(int'(reg_sy), 1, MAX_SCALE);
      scr_w = clamp_int(int'(reg_w), 1, MAX_SCREEN);
      scr_h = clamp_int(int'(reg_h), 1, MAX_SCREEN);
      case (cmd)
         btr_pkg::CMD_LOAD: begin
            if (int'(addr) < GLYPH_DEPTH) glyph_mem[addr] = data;
         end
         btr_pkg::CMD_CURSOR: begin
            cur_col = nx;
            cur_row = ny;
         end
         btr_pkg::CMD_DRAW: begin
            if (code == btr_pkg::CHAR_NEWLINE) begin
               cur_col = '0;
               cur_row = cur_row + 16'(sy * GLYPH_ROWS);
            end else if (code != btr_pkg::CHAR_RETURN) begin
               // Wrap first when the cell would run past the right edge.
               if (int'($signed(cur_col)) + sx * CELL_DOTS > scr_w) begin
                  cur_col = '0;
                  cur_row = cur_row + 16'(sy * GLYPH_ROWS);
               end
               draw_glyph(int'($signed(cur_col)), int'($signed(cur_row)), code, sx, sy,
                          scr_w, scr_h);
               cur_col = cur_col + 16'(sx * CELL_DOTS);
            end
         end
         default: ;
      endcase
   endfunction

   // Sends one request word. Valid is only lowered when the sender idles, so
   // back-to-back words keep it high without a second assignment in a step.
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] code,
                            input logic [10:0] addr, input logic [7:0] data,
                            input logic [15:0] nx, input logic [15:0] ny);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_char_code    <= code;
      req_glyph_addr   <= addr;
      req_glyph_byte   <= data;
      req_new_cursor_x <= nx;
      req_new_cursor_y <= ny;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_rectangles(cmd, code, addr, data, nx, ny);
   endtask

   task automatic draw_char(input logic [7:0] code);
      send_word(btr_pkg::CMD_DRAW, code, 11'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom));
   endtask

   task automatic move_cursor(input logic [15:0] nx, input logic [15:0] ny);
      send_word(btr_pkg::CMD_CURSOR, 8'($urandom), 11'($urandom), 8'($urandom), nx, ny);
   endtask

   // Stops sending, waits for every predicted rectangle and then lets the
   // engine finish any queued glyph that produces nothing visible.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input btr_pkg::csr_index_type idx, input logic [15:0] val);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      case (idx)
         btr_pkg::CSR_SCALE_X:       reg_sx = val[3:0];
         btr_pkg::CSR_SCALE_Y:       reg_sy = val[3:0];
         btr_pkg::CSR_FG_COLOR:      reg_fg = val;
         btr_pkg::CSR_BG_COLOR:      reg_bg = val;
         btr_pkg::CSR_SCREEN_WIDTH:  reg_w  = val[10:0];
         btr_pkg::CSR_SCREEN_HEIGHT: reg_h  = val[10:0];
         default: ;
      endcase
   endtask

   // Writes all six registers on consecutive cycles; only called while idle.
   task automatic configure(input logic [3:0] sx, input logic [3:0] sy,
                            input logic [15:0] fg, input logic [15:0] bg,
                            input logic [10:0] w, input logic [10:0] h);
      write_reg(btr_pkg::CSR_SCALE_X, 16'(sx));
      write_reg(btr_pkg::CSR_SCALE_Y, 16'(sy));
      write_reg(btr_pkg::CSR_FG_COLOR, fg);
      write_reg(btr_pkg::CSR_BG_COLOR, bg);
      write_reg(btr_pkg::CSR_SCREEN_WIDTH, 16'(w));
      write_reg(btr_pkg::CSR_SCREEN_HEIGHT, 16'(h));
      csr_write_en <= 1'b0;
   endtask

   // Scales and screen sizes lean toward small values with the extremes and
   // out-of-range codes mixed in.
   function automatic logic [3:0] pick_scale();
      case ($urandom_range(9))
         0: return 4'd0;
         1: return 4'd15;
         2: return 4'd8;
         3: return 4'd9;
         default: return 4'($urandom_range(1, 3));
      endcase
   endfunction

   function automatic logic [10:0] pick_size();
      case ($urandom_range(9))
         0: return 11'd0;
         1: return 11'd2047;
         2: return 11'd1024;
         3: return 11'd1;
         default: return 11'($urandom_range(8, 160));
      endcase
   endfunction

   // Loads every glyph that a drawn character code can reach, so no draw ever
   // reads an entry that was never written. Glyph 0 is fully set and glyph 1
   // fully clear; the rest is random.
   task automatic test_glyph_load();
      logic [7:0] data;
      int         base;
      for (int k = 0; k < LOADED_COUNT; k++) begin
         base = loaded_glyph(k) * GLYPH_COLS;
         for (int c = 0; c < GLYPH_COLS; c++) begin
            if (k == 0) data = 8'hFF;
            else if (k == 1) data = 8'h00;
            else data = 8'($urandom_range(255));
            send_word(btr_pkg::CMD_LOAD, 8'($urandom), 11'(base + c), data,
                      16'($urandom), 16'($urandom));
         end
      end
      wait_for_quiet();
   endtask

   // Cursor movement, control codes and the high-code glyph skip under the
   // reset settings: unit scale, transparent background, 128 by 160 screen.
   task automatic test_text_flow();
      move_cursor(16'd0, 16'd0);
      draw_char(8'd0);
      draw_char(8'd1);
      draw_char(8'd255);
      draw_char(btr_pkg::HIGH_CODE_START);
      draw_char(8'd175);
      draw_char(btr_pkg::CHAR_NEWLINE);
      draw_char(btr_pkg::CHAR_RETURN);
      send_word(CMD_UNUSED, 8'd65, 11'd2047, 8'hFF, 16'hFFFF, 16'hFFFF);
      move_cursor(16'd124, 16'd8);      // cell runs past the right edge and wraps
      draw_char(8'd65);
      move_cursor(-16'sd3, -16'sd2);    // partly above and left of the screen
      draw_char(8'd0);
      move_cursor(16'd0, 16'd170);      // below the screen
      draw_char(8'd0);
      move_cursor(16'h7FFF, 16'h7FFF);  // the wrap pushes the row past 16 bits
      draw_char(8'd0);
      move_cursor(16'h8000, 16'h8000);
      draw_char(8'd0);
      wait_for_quiet();
   endtask

   // Clipping at the right and bottom edges, opaque backgrounds and the
   // register extremes, including codes beyond each register's range.
   task automatic test_clipping();
      configure(4'd3, 4'd2, 16'h0000, 16'hFFFF, 11'd10, 11'd20);
      move_cursor(-16'sd4, 16'd12);
      draw_char(8'd0);
      draw_char(8'd1);
      wait_for_quiet();
      configure(4'd1, 4'd1, 16'h001F, 16'hF800, 11'd1024, 11'd1024);
      move_cursor(16'd1017, 16'd1020);
      draw_char(8'd0);
      wait_for_quiet();
      configure(4'd8, 4'd8, 16'hFFFF, 16'h0000, 11'd1024, 11'd1024);
      draw_char(8'd0);
      wait_for_quiet();
      configure(4'd0, 4'd15, 16'h5A5A, 16'hA5A5, 11'd0, 11'd2047);
      draw_char(8'd0);
      wait_for_quiet();
      configure(4'd15, 4'd0, 16'h0000, 16'h0000, 11'd2047, 11'd1);
      draw_char(8'd0);
      wait_for_quiet();
   endtask

   // Random traffic in four rounds, each under fresh register settings.
   // Most words draw text; loads, cursor moves and the spare code mix in.
   task automatic test_random_traffic(input int send_gap, input int recv_stall);
      int          pick;
      int          lim_w;
      int          lim_h;
      logic [7:0]  code;
      logic [10:0] addr;
      logic [7:0]  data;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] fg_pick;
      logic [15:0] bg_pick;
      gap_pct   = send_gap;
      stall_pct = recv_stall;
      repeat (4) begin
         fg_pick = 16'($urandom);
         // A transparent background about half the time.
         bg_pick = ($urandom_range(1) == 0) ? fg_pick : 16'($urandom);
         configure(pick_scale(), pick_scale(), fg_pick, bg_pick, pick_size(), pick_size());
         lim_w = clamp_int(int'(reg_w), 1, MAX_SCREEN);
         lim_h = clamp_int(int'(reg_h), 1, MAX_SCREEN);
         repeat (11) begin
            code = 8'($urandom);
            addr = 11'($urandom);
            data = 8'($urandom);
            nx   = 16'($urandom);
            ny   = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 20) begin
               if ($urandom_range(3) != 0) addr = 11'($urandom_range(0, FONT_BYTES - 1));
               send_word(btr_pkg::CMD_LOAD, code, addr, data, nx, ny);
            end else if (pick < 35) begin
               // Mostly near the screen so that text lands on it.
               if ($urandom_range(3) != 0) begin
                  nx = 16'(int'($urandom_range(0, lim_w + 30)) - 30);
                  ny = 16'(int'($urandom_range(0, lim_h + 30)) - 30);
               end
               send_word(btr_pkg::CMD_CURSOR, code, addr, data, nx, ny);
            end else if (pick < 40) begin
               send_word(CMD_UNUSED, code, addr, data, nx, ny);
            end else begin
               case ($urandom_range(19))
                  0, 1:    code = btr_pkg::CHAR_NEWLINE;
                  2:       code = btr_pkg::CHAR_RETURN;
                  default: code = pick_code();
               endcase
               send_word(btr_pkg::CMD_DRAW, code, addr, data, nx, ny);
            end
         end
         // The sender holds off here until every rectangle has come back.
         wait_for_quiet();
      end
   endtask

   // The receiver stalls at random; with a zero chance it is always ready.
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // Every accepted rectangle is matched against the oldest prediction.
   always @(posedge clock) begin : check_rects
      rect_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rects.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected rectangle: x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                        rsp_rect_x, rsp_rect_y, rsp_rect_w, rsp_rect_h, rsp_color, rsp_last);
         end else begin
            want = pending_rects.pop_front();
            if (rsp_rect_x !== want.x || rsp_rect_y !== want.y || rsp_rect_w !== want.w ||
                rsp_rect_h !== want.h || rsp_color !== want.color || rsp_last !== want.last)
            begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("rectangle mismatch: expected x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                           want.x, want.y, want.w, want.h, want.color, want.last);
                  $display("                    got      x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                           rsp_rect_x, rsp_rect_y, rsp_rect_w, rsp_rect_h, rsp_color,
                           rsp_last);
               end
            end
         end
      end
   end

   // Main sequence: reset once, then the tests in turn. The three random
   // passes move the idling from the receiver to the sender and then drop it.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_glyph_load();
      test_text_flow();
      test_clipping();
      test_random_traffic(26, 87);
      test_random_traffic(87, 26);
      test_random_traffic(0, 0);
      if (errors == 0 && pending_rects.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // A hung handshake or a missing rectangle ends the run here.
   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

endmodule
